// File: sv/dms_pkg.sv
`timescale 1ns / 1ps
// Shared types and microcode table of the decimal magnitude subtractor.
// No dependencies; used by dms_seq and decimal_magnitude_subtractor.
package dms_pkg;

    // Datapath operation selected by the current control word
    typedef enum logic [4:0] {
        OP_IDLE = 5'b00001,
        OP_CMP  = 5'b00010,
        OP_SUB  = 5'b00100,
        OP_EMIT = 5'b01000,
        OP_DONE = 5'b10000
    } t_op;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_IDLE = 3'd0;
    localparam t_step ST_CMP  = 3'd1;
    localparam t_step ST_SUB  = 3'd2;
    localparam t_step ST_EMIT = 3'd3;
    localparam t_step ST_DONE = 3'd4;

    // One control word of the program
    typedef struct packed {
        t_op   op;
        logic  wait_start;  // hold until a start request
        logic  stallable;   // hold while the output slot is full
        logic  loop;        // repeat until the digit counter wraps
        t_step next;
    } t_uword;

    // Control handed from the sequencer to the datapath
    typedef struct packed {
        t_op  op;
        logic final_iter;
        logic advance;
    } t_ctrl;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [4:0] RADIX     = 5'd10;

    function automatic t_uword uword(input t_step pc);
        t_uword w;
        case (pc)
            ST_IDLE: w = '{op: OP_IDLE, wait_start: 1'b1, stallable: 1'b0, loop: 1'b0,
                           next: ST_CMP};
            ST_CMP:  w = '{op: OP_CMP,  wait_start: 1'b0, stallable: 1'b0, loop: 1'b1,
                           next: ST_SUB};
            ST_SUB:  w = '{op: OP_SUB,  wait_start: 1'b0, stallable: 1'b0, loop: 1'b1,
                           next: ST_EMIT};
            ST_EMIT: w = '{op: OP_EMIT, wait_start: 1'b0, stallable: 1'b1, loop: 1'b1,
                           next: ST_DONE};
            ST_DONE: w = '{op: OP_DONE, wait_start: 1'b0, stallable: 1'b0, loop: 1'b0,
                           next: ST_IDLE};
            default: w = '{op: OP_DONE, wait_start: 1'b0, stallable: 1'b0, loop: 1'b0,
                           next: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: sv/dms_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, digit loop counter and control table.
// Depends on dms_pkg.
module dms_seq
    import dms_pkg::*;
#(
    parameter int DIGITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_stall,
    output t_ctrl o_ctrl
);

    localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    t_step   r_pc, n_pc;
    logic [CW-1:0] r_cnt, n_cnt;
    t_uword  w_uw;
    logic    w_done;
    logic    w_adv;

    assign w_uw   = uword(r_pc);
    assign w_done = (r_cnt == CW'(DIGITS - 1));

    always_comb begin
        n_pc  = r_pc;
        n_cnt = r_cnt;
        w_adv = 1'b1;
        if (w_uw.wait_start && !i_start) begin
            w_adv = 1'b0;
        end else if (w_uw.stallable && i_stall) begin
            w_adv = 1'b0;
        end else if (w_uw.loop && !w_done) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_pc  = w_uw.next;
            n_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= ST_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    assign o_ctrl = '{op: w_uw.op, final_iter: w_done, advance: w_adv};

endmodule

// File: sv/decimal_magnitude_subtractor.sv
`timescale 1ns / 1ps
// Decimal magnitude subtractor: digits load at one per cycle while idle.
// After the final digit of the second number: compare, subtract, emit (held
// while the output stalls), then clear; the next pair loads after that. The
// digit shift lines and the microcode step counter sequence these steps.
// Reset (i_rst_n low, synchronous) clears both stores, counts and flags.
module decimal_magnitude_subtractor
    import dms_pkg::*;
#(
    parameter int DIGITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [3:0] digit, [7:4] zero
    input  logic       i_s_tlast,   // last_digit
    input  logic       i_s_tuser,   // [0] action
    // result stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [3:0] digit_res, [7:4] zero
    output logic       o_m_tlast,   // last
    output logic [1:0] o_m_tuser    // [0] negative, [1] too_long
);

    localparam int CNT_W = $clog2(DIGITS + 1);

    t_ctrl w_ctrl;

    // Digit stores, index 0 is the least significant digit
    logic [DIGITS-1:0][3:0] r_a, n_a;
    logic [DIGITS-1:0][3:0] r_b, n_b;
    logic [CNT_W-1:0] r_a_cnt, n_a_cnt;
    logic [CNT_W-1:0] r_b_cnt, n_b_cnt;
    logic r_ovf, n_ovf;
    logic r_decided, n_decided;
    logic r_neg, n_neg;
    logic r_borrow, n_borrow;
    logic r_started, n_started;

    logic r_out_valid, n_out_valid;
    logic [3:0] r_out_digit, n_out_digit;
    logic r_out_last, n_out_last;
    logic r_out_neg, n_out_neg;
    logic r_out_ovf, n_out_ovf;

    logic w_in_acc;
    logic w_start;
    logic w_stall;
    logic [3:0] w_din;
    logic [3:0] w_big, w_small;
    logic [4:0] w_sub, w_sum;
    logic w_ge;
    logic w_emit;

    assign o_s_tready = (w_ctrl.op == OP_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_start    = w_in_acc && i_s_tuser && i_s_tlast;
    // output slot still occupied by an untaken transaction
    assign w_stall    = r_out_valid && !i_m_tready;

    // clamp codes above nine
    assign w_din = (i_s_tdata[3:0] > DIGIT_MAX) ? DIGIT_MAX : i_s_tdata[3:0];

    // one decimal subtract digit, least significant first
    assign w_big   = r_neg ? r_b[0] : r_a[0];
    assign w_small = r_neg ? r_a[0] : r_b[0];
    assign w_sub   = {1'b0, w_small} + {4'd0, r_borrow};
    assign w_ge    = ({1'b0, w_big} >= w_sub);
    assign w_sum   = {1'b0, w_big} + (w_ge ? 5'd0 : RADIX) - w_sub;

    // suppress leading zeros but always give the units digit
    assign w_emit = (w_ctrl.op == OP_EMIT) && w_ctrl.advance &&
                    ((r_a[DIGITS-1] != 4'd0) || r_started || w_ctrl.final_iter);

    dms_seq #(
        .DIGITS (DIGITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stall (w_stall),
        .o_ctrl  (w_ctrl)
    );

    always_comb begin
        n_a       = r_a;
        n_b       = r_b;
        n_a_cnt   = r_a_cnt;
        n_b_cnt   = r_b_cnt;
        n_ovf     = r_ovf;
        n_decided = r_decided;
        n_neg     = r_neg;
        n_borrow  = r_borrow;
        n_started = r_started;

        case (w_ctrl.op)
            OP_IDLE: begin
                // shift a digit into the addressed store
                if (w_in_acc) begin
                    if (!i_s_tuser) begin
                        for (int i = 1; i < DIGITS; i++) n_a[i] = r_a[i-1];
                        n_a[0] = w_din;
                        if (r_a_cnt == CNT_W'(DIGITS)) n_ovf = 1'b1;
                        else n_a_cnt = r_a_cnt + 1'b1;
                    end else begin
                        for (int i = 1; i < DIGITS; i++) n_b[i] = r_b[i-1];
                        n_b[0] = w_din;
                        if (r_b_cnt == CNT_W'(DIGITS)) n_ovf = 1'b1;
                        else n_b_cnt = r_b_cnt + 1'b1;
                    end
                end
            end
            OP_CMP: begin
                // rotate both stores upward, first differing digit decides
                for (int i = 1; i < DIGITS; i++) begin
                    n_a[i] = r_a[i-1];
                    n_b[i] = r_b[i-1];
                end
                n_a[0] = r_a[DIGITS-1];
                n_b[0] = r_b[DIGITS-1];
                if (!r_decided && (r_a[DIGITS-1] != r_b[DIGITS-1])) begin
                    n_decided = 1'b1;
                    n_neg     = (r_b[DIGITS-1] > r_a[DIGITS-1]);
                end
            end
            OP_SUB: begin
                // rotate downward; difference replaces the first store
                for (int i = 0; i < DIGITS - 1; i++) begin
                    n_a[i] = r_a[i+1];
                    n_b[i] = r_b[i+1];
                end
                n_a[DIGITS-1] = w_sum[3:0];
                n_b[DIGITS-1] = 4'd0;
                n_borrow      = !w_ge;
            end
            OP_EMIT: begin
                // read the top digit, clear behind it
                if (w_ctrl.advance) begin
                    for (int i = 1; i < DIGITS; i++) n_a[i] = r_a[i-1];
                    n_a[0] = 4'd0;
                    if (w_emit) n_started = 1'b1;
                end
            end
            OP_DONE: begin
                n_a_cnt   = '0;
                n_b_cnt   = '0;
                n_ovf     = 1'b0;
                n_decided = 1'b0;
                n_neg     = 1'b0;
                n_borrow  = 1'b0;
                n_started = 1'b0;
            end
            default: begin
                n_a = r_a;
            end
        endcase
    end

    // output register: load on emit, drop when taken
    always_comb begin
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_digit = r_out_digit;
        n_out_last  = r_out_last;
        n_out_neg   = r_out_neg;
        n_out_ovf   = r_out_ovf;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out_digit = r_a[DIGITS-1];
            n_out_last  = w_ctrl.final_iter;
            n_out_neg   = r_neg;
            n_out_ovf   = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= '0;
            r_b         <= '0;
            r_a_cnt     <= '0;
            r_b_cnt     <= '0;
            r_ovf       <= 1'b0;
            r_decided   <= 1'b0;
            r_neg       <= 1'b0;
            r_borrow    <= 1'b0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a         <= n_a;
            r_b         <= n_b;
            r_a_cnt     <= n_a_cnt;
            r_b_cnt     <= n_b_cnt;
            r_ovf       <= n_ovf;
            r_decided   <= n_decided;
            r_neg       <= n_neg;
            r_borrow    <= n_borrow;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_digit <= n_out_digit;
        r_out_last  <= n_out_last;
        r_out_neg   <= n_out_neg;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_digit};
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_ovf, r_out_neg};

    // a result transaction only appears out of the emit step
    a_emit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_ctrl.op == OP_EMIT))
        else $error("result appeared outside the emit step");

    // larger minus smaller never leaves a borrow past the top digit
    a_no_borrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_EMIT) |-> !r_borrow)
        else $error("borrow left after subtraction");

    // both stores are empty by the time the pair is retired
    a_stores_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_DONE) |-> (r_a == '0 && r_b == '0))
        else $error("digit store not cleared at end of answer");

endmodule
